// ===== rtl/core/pts_pkg.sv =====
package pts_pkg;

    localparam int NUM_THREADS_DEF = 32;
    localparam int PRIO_BITS_DEF   = 8;

    // request codes
    localparam logic [1:0] REQ_RESCHED   = 2'd0;
    localparam logic [1:0] REQ_ENQUEUE   = 2'd1;
    localparam logic [1:0] REQ_DEFER_BEG = 2'd2;
    localparam logic [1:0] REQ_DEFER_END = 2'd3;

    // queue operations
    localparam logic [1:0] Q_NOP    = 2'd0;
    localparam logic [1:0] Q_INSERT = 2'd1;
    localparam logic [1:0] Q_POP    = 2'd2;

    localparam logic [7:0] DEFER_MAX = 8'd255;

    typedef struct packed {
        logic prio;
        logic rstart;
        logic cpu;
        logic rc;
        logic resp;
    } mem_we_t;

endpackage

// ===== rtl/core/pts_cell.sv =====
module pts_cell #(
    parameter int IW = 5,
    parameter int KW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [1:0]    op,
    input  logic [IW-1:0] ins_id,
    input  logic [KW-1:0] ins_key,
    input  logic          prev_ge,
    input  logic [IW-1:0] left_id,
    input  logic [KW-1:0] left_key,
    input  logic          left_valid,
    input  logic [IW-1:0] right_id,
    input  logic [KW-1:0] right_key,
    input  logic          right_valid,
    output logic [IW-1:0] id,
    output logic [KW-1:0] key,
    output logic          valid,
    output logic          ge
);

    logic [IW-1:0] id_reg, id_next;
    logic [KW-1:0] key_reg, key_next;
    logic          valid_reg, valid_next;

    assign ge = valid_reg && (key_reg >= ins_key);

    always_comb
    begin
        id_next    = id_reg;
        key_next   = key_reg;
        valid_next = valid_reg;
        case (op)
            pts_pkg::Q_INSERT:
            begin
                if (!ge)
                begin
                    // first slot below the new key takes it, the rest shift down
                    if (prev_ge)
                    begin
                        id_next    = ins_id;
                        key_next   = ins_key;
                        valid_next = 1'b1;
                    end
                    else
                    begin
                        id_next    = left_id;
                        key_next   = left_key;
                        valid_next = left_valid;
                    end
                end
            end
            pts_pkg::Q_POP:
            begin
                id_next    = right_id;
                key_next   = right_key;
                valid_next = right_valid;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        id_reg  <= id_next;
        key_reg <= key_next;
    end

    assign id    = id_reg;
    assign key   = key_reg;
    assign valid = valid_reg;

endmodule

// ===== rtl/core/pts_queue.sv =====
module pts_queue #(
    parameter int N  = 32,
    parameter int IW = 5,
    parameter int KW = 8,
    parameter int CW = 6
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [1:0]    op,
    input  logic [IW-1:0] ins_id,
    input  logic [KW-1:0] ins_key,
    output logic [IW-1:0] head_id,
    output logic [KW-1:0] head_key,
    output logic [CW-1:0] count
);

    logic [IW-1:0] c_id    [N];
    logic [KW-1:0] c_key   [N];
    logic          c_valid [N];
    logic          c_ge    [N];
    logic [CW-1:0] count_reg, count_next;

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        logic [IW-1:0] l_id, r_id;
        logic [KW-1:0] l_key, r_key;
        logic          l_valid, r_valid, p_ge;

        if (i == 0)
        begin : g_first
            assign l_id    = '0;
            assign l_key   = '0;
            assign l_valid = 1'b0;
            assign p_ge    = 1'b1;
        end
        else
        begin : g_mid
            assign l_id    = c_id[i-1];
            assign l_key   = c_key[i-1];
            assign l_valid = c_valid[i-1];
            assign p_ge    = c_ge[i-1];
        end

        if (i == N - 1)
        begin : g_last
            assign r_id    = '0;
            assign r_key   = '0;
            assign r_valid = 1'b0;
        end
        else
        begin : g_inner
            assign r_id    = c_id[i+1];
            assign r_key   = c_key[i+1];
            assign r_valid = c_valid[i+1];
        end

        pts_cell #(.IW(IW), .KW(KW)) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .op          (op),
            .ins_id      (ins_id),
            .ins_key     (ins_key),
            .prev_ge     (p_ge),
            .left_id     (l_id),
            .left_key    (l_key),
            .left_valid  (l_valid),
            .right_id    (r_id),
            .right_key   (r_key),
            .right_valid (r_valid),
            .id          (c_id[i]),
            .key         (c_key[i]),
            .valid       (c_valid[i]),
            .ge          (c_ge[i])
        );
    end

    always_comb
    begin
        case (op)
            pts_pkg::Q_INSERT: count_next = count_reg + CW'(1);
            pts_pkg::Q_POP:    count_next = count_reg - CW'(1);
            default:           count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    assign head_id  = c_id[0];
    assign head_key = c_key[0];
    assign count    = count_reg;

endmodule

// ===== rtl/core/pts_thread_mem.sv =====
module pts_thread_mem #(
    parameter int N  = 32,
    parameter int AW = 5,
    parameter int PW = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [AW-1:0]   rd_addr,
    input  logic [AW-1:0]   wr_addr,
    input  pts_pkg::mem_we_t we,
    input  logic [PW-1:0]   wr_prio,
    input  logic [31:0]     wr_rstart,
    input  logic [31:0]     wr_cpu,
    input  logic [31:0]     wr_rc,
    input  logic [31:0]     wr_resp,
    output logic [PW-1:0]   rd_prio,
    output logic [31:0]     rd_rstart,
    output logic [31:0]     rd_cpu,
    output logic [31:0]     rd_rc,
    output logic [31:0]     rd_resp
);

    logic [PW-1:0] mem_prio   [N];
    logic [31:0]   mem_rstart [N];
    logic [31:0]   mem_cpu    [N];
    logic [31:0]   mem_rc     [N];
    logic [31:0]   mem_resp   [N];

    // unwritten entries read as zero
    logic [N-1:0] v_prio_reg, v_rstart_reg, v_cpu_reg, v_rc_reg, v_resp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_prio_reg   <= '0;
            v_rstart_reg <= '0;
            v_cpu_reg    <= '0;
            v_rc_reg     <= '0;
            v_resp_reg   <= '0;
        end
        else
        begin
            if (we.prio)   v_prio_reg[wr_addr]   <= 1'b1;
            if (we.rstart) v_rstart_reg[wr_addr] <= 1'b1;
            if (we.cpu)    v_cpu_reg[wr_addr]    <= 1'b1;
            if (we.rc)     v_rc_reg[wr_addr]     <= 1'b1;
            if (we.resp)   v_resp_reg[wr_addr]   <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we.prio)   mem_prio[wr_addr]   <= wr_prio;
        if (we.rstart) mem_rstart[wr_addr] <= wr_rstart;
        if (we.cpu)    mem_cpu[wr_addr]    <= wr_cpu;
        if (we.rc)     mem_rc[wr_addr]     <= wr_rc;
        if (we.resp)   mem_resp[wr_addr]   <= wr_resp;
        rd_prio   <= v_prio_reg[rd_addr]   ? mem_prio[rd_addr]   : '0;
        rd_rstart <= v_rstart_reg[rd_addr] ? mem_rstart[rd_addr] : '0;
        rd_cpu    <= v_cpu_reg[rd_addr]    ? mem_cpu[rd_addr]    : '0;
        rd_rc     <= v_rc_reg[rd_addr]     ? mem_rc[rd_addr]     : '0;
        rd_resp   <= v_resp_reg[rd_addr]   ? mem_resp[rd_addr]   : '0;
    end

endmodule

// ===== rtl/core/priority_thread_scheduler.sv =====
// Channel | Handshake            | Payload
// in      | in_valid / in_ready   | req_type thread_id priority_req ready_start_msec
//         |                       | still_current cpu_ticks now_msec
// out     | out_valid / out_ready | next_thread switched deferred missed_resched
//         |                       | queue_empty_error tick_clear old_total_cpu
//         |                       | old_ready_count new_total_resp
// One transaction at a time; in_ready is high only while the sequencer idles.
// Items run serially from accept to result; a reschedule steps through the thread
// memory and the queue chain in turn (pop, insert, second pop are separate cycles).
// Reset clears the queue valid bits, counters and the thread memory valid bits
// at once; no clearing pass. A result waiting on out_ready holds the sequencer.
module priority_thread_scheduler #(
    parameter int NUM_THREADS = pts_pkg::NUM_THREADS_DEF,
    parameter int PRIO_BITS   = pts_pkg::PRIO_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [4:0]  thread_id,
    input  logic [7:0]  priority_req,
    input  logic [31:0] ready_start_msec,
    input  logic        still_current,
    input  logic [15:0] cpu_ticks,
    input  logic [31:0] now_msec,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [4:0]  next_thread,
    output logic        switched,
    output logic        deferred,
    output logic        missed_resched,
    output logic        queue_empty_error,
    output logic        tick_clear,
    output logic [31:0] old_total_cpu,
    output logic [31:0] old_ready_count,
    output logic [31:0] new_total_resp
);

    localparam int AW = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;
    localparam int CW = $clog2(NUM_THREADS + 1);
    localparam int PW = PRIO_BITS;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_START = 4'd1;
    localparam logic [3:0] S_CUR   = 4'd2;
    localparam logic [3:0] S_INS   = 4'd3;
    localparam logic [3:0] S_POP2  = 4'd4;
    localparam logic [3:0] S_RDN   = 4'd5;
    localparam logic [3:0] S_RESP  = 4'd6;
    localparam logic [3:0] S_DONE  = 4'd7;

    logic [3:0]  state_reg, state_next;
    logic [AW-1:0] cur_reg, cur_next;
    logic [AW-1:0] n_reg, n_next;
    logic [PW-1:0] pc_reg, pc_next;
    logic [7:0]  defer_reg, defer_next;

    // latched item
    logic [1:0]  req_reg;
    logic [4:0]  tid_reg;
    logic [7:0]  prio_reg;
    logic [31:0] rstart_reg;
    logic        still_reg;
    logic [15:0] ticks_reg;
    logic [31:0] now_reg;

    // result under construction
    logic        r_sw_reg, r_sw_next;
    logic        r_def_reg, r_def_next;
    logic        r_miss_reg, r_miss_next;
    logic        r_err_reg, r_err_next;
    logic        r_tick_reg, r_tick_next;
    logic [31:0] r_cpu_reg, r_cpu_next;
    logic [31:0] r_rc_reg, r_rc_next;
    logic [31:0] r_resp_reg, r_resp_next;

    logic        out_valid_reg;
    logic [4:0]  o_next_reg;
    logic        o_sw_reg, o_def_reg, o_miss_reg, o_err_reg, o_tick_reg;
    logic [31:0] o_cpu_reg, o_rc_reg, o_resp_reg;

    logic        accept, out_free;

    logic [1:0]    q_op;
    logic [AW-1:0] q_id;
    logic [PW-1:0] q_key;
    logic [AW-1:0] head_id;
    logic [PW-1:0] head_key;
    logic [CW-1:0] q_count;

    logic [AW-1:0]    rd_addr, wr_addr;
    pts_pkg::mem_we_t we;
    logic [PW-1:0]    wr_prio, rd_prio;
    logic [31:0]      wr_rstart, wr_cpu, wr_rc, wr_resp;
    logic [31:0]      rd_rstart, rd_cpu, rd_rc, rd_resp;

    logic        tid_ok, q_full, q_empty;
    logic [31:0] cpu_sum;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || out_ready;

    assign tid_ok  = (32'(tid_reg) < 32'(NUM_THREADS));
    assign q_full  = (q_count == CW'(NUM_THREADS));
    assign q_empty = (q_count == '0);
    assign cpu_sum = rd_cpu + ((ticks_reg == 16'd0) ? 32'd1 : 32'(ticks_reg));

    pts_queue #(.N(NUM_THREADS), .IW(AW), .KW(PW), .CW(CW)) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (q_op),
        .ins_id   (q_id),
        .ins_key  (q_key),
        .head_id  (head_id),
        .head_key (head_key),
        .count    (q_count)
    );

    pts_thread_mem #(.N(NUM_THREADS), .AW(AW), .PW(PW)) u_mem (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_addr   (rd_addr),
        .wr_addr   (wr_addr),
        .we        (we),
        .wr_prio   (wr_prio),
        .wr_rstart (wr_rstart),
        .wr_cpu    (wr_cpu),
        .wr_rc     (wr_rc),
        .wr_resp   (wr_resp),
        .rd_prio   (rd_prio),
        .rd_rstart (rd_rstart),
        .rd_cpu    (rd_cpu),
        .rd_rc     (rd_rc),
        .rd_resp   (rd_resp)
    );

    always_comb
    begin
        state_next  = state_reg;
        cur_next    = cur_reg;
        n_next      = n_reg;
        pc_next     = pc_reg;
        defer_next  = defer_reg;
        r_sw_next   = r_sw_reg;
        r_def_next  = r_def_reg;
        r_miss_next = r_miss_reg;
        r_err_next  = r_err_reg;
        r_tick_next = r_tick_reg;
        r_cpu_next  = r_cpu_reg;
        r_rc_next   = r_rc_reg;
        r_resp_next = r_resp_reg;
        q_op        = pts_pkg::Q_NOP;
        q_id        = cur_reg;
        q_key       = pc_reg;
        rd_addr     = cur_reg;
        wr_addr     = cur_reg;
        we          = '0;
        wr_prio     = PW'(prio_reg);
        wr_rstart   = rstart_reg;
        wr_cpu      = cpu_sum;
        wr_rc       = rd_rc + 32'd1;
        wr_resp     = rd_resp + (now_reg - rd_rstart);

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next  = S_START;
                    r_sw_next   = 1'b0;
                    r_def_next  = 1'b0;
                    r_miss_next = 1'b0;
                    r_err_next  = 1'b0;
                    r_tick_next = 1'b0;
                    r_cpu_next  = '0;
                    r_rc_next   = '0;
                    r_resp_next = '0;
                end
            end
            S_START:
            begin
                state_next = S_DONE;
                case (req_reg)
                    pts_pkg::REQ_ENQUEUE:
                    begin
                        if (tid_ok && !q_full)
                        begin
                            wr_addr   = AW'(tid_reg);
                            we.prio   = 1'b1;
                            we.rstart = 1'b1;
                            q_op      = pts_pkg::Q_INSERT;
                            q_id      = AW'(tid_reg);
                            q_key     = PW'(prio_reg);
                        end
                    end
                    pts_pkg::REQ_DEFER_BEG:
                    begin
                        if (defer_reg == 8'd0)
                            defer_next = 8'd1;
                    end
                    pts_pkg::REQ_DEFER_END:
                    begin
                        r_miss_next = (defer_reg > 8'd1);
                        defer_next  = 8'd0;
                    end
                    default:
                    begin
                        if (defer_reg != 8'd0)
                        begin
                            if (defer_reg != pts_pkg::DEFER_MAX)
                                defer_next = defer_reg + 8'd1;
                            r_def_next = 1'b1;
                        end
                        else
                        begin
                            // fetch the current thread's row
                            state_next = S_CUR;
                        end
                    end
                endcase
            end
            S_CUR:
            begin
                if (still_reg)
                begin
                    we.cpu     = 1'b1;
                    r_cpu_next = cpu_sum;
                    if (!q_empty && (rd_prio > head_key))
                    begin
                        r_tick_next = 1'b1;
                        r_rc_next   = rd_rc;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        we.rc     = 1'b1;
                        r_rc_next = rd_rc + 32'd1;
                        pc_next   = rd_prio;
                        state_next = S_INS;
                        if (q_empty)
                            n_next = cur_reg;
                        else
                        begin
                            n_next = head_id;
                            q_op   = pts_pkg::Q_POP;
                        end
                    end
                end
                else
                begin
                    r_cpu_next = rd_cpu;
                    r_rc_next  = rd_rc;
                    if (q_empty)
                    begin
                        r_err_next = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        n_next     = head_id;
                        q_op       = pts_pkg::Q_POP;
                        state_next = S_RDN;
                    end
                end
            end
            S_INS:
            begin
                // requeue current behind its equals
                q_op  = pts_pkg::Q_INSERT;
                q_id  = cur_reg;
                q_key = pc_reg;
                state_next = (n_reg == cur_reg) ? S_POP2 : S_RDN;
            end
            S_POP2:
            begin
                n_next     = head_id;
                q_op       = pts_pkg::Q_POP;
                state_next = S_RDN;
            end
            S_RDN:
            begin
                rd_addr    = n_reg;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                wr_addr     = n_reg;
                we.resp     = 1'b1;
                cur_next    = n_reg;
                r_sw_next   = 1'b1;
                r_resp_next = wr_resp;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_reg       <= '0;
            defer_reg     <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cur_reg   <= cur_next;
            defer_reg <= defer_next;
            if (state_reg == S_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg    <= req_type;
            tid_reg    <= thread_id;
            prio_reg   <= priority_req;
            rstart_reg <= ready_start_msec;
            still_reg  <= still_current;
            ticks_reg  <= cpu_ticks;
            now_reg    <= now_msec;
        end
        n_reg      <= n_next;
        pc_reg     <= pc_next;
        r_sw_reg   <= r_sw_next;
        r_def_reg  <= r_def_next;
        r_miss_reg <= r_miss_next;
        r_err_reg  <= r_err_next;
        r_tick_reg <= r_tick_next;
        r_cpu_reg  <= r_cpu_next;
        r_rc_reg   <= r_rc_next;
        r_resp_reg <= r_resp_next;
        if (state_reg == S_DONE && out_free)
        begin
            o_next_reg <= 5'(cur_reg);
            o_sw_reg   <= r_sw_reg;
            o_def_reg  <= r_def_reg;
            o_miss_reg <= r_miss_reg;
            o_err_reg  <= r_err_reg;
            o_tick_reg <= r_tick_reg;
            o_cpu_reg  <= r_cpu_reg;
            o_rc_reg   <= r_rc_reg;
            o_resp_reg <= r_resp_reg;
        end
    end

    assign out_valid         = out_valid_reg;
    assign next_thread       = o_next_reg;
    assign switched          = o_sw_reg;
    assign deferred          = o_def_reg;
    assign missed_resched    = o_miss_reg;
    assign queue_empty_error = o_err_reg;
    assign tick_clear        = o_tick_reg;
    assign old_total_cpu     = o_cpu_reg;
    assign old_ready_count   = o_rc_reg;
    assign new_total_resp    = o_resp_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= CW'(NUM_THREADS))
        else $error("ready queue count above capacity");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("new transaction taken while one is in flight");

    a_err_no_switch: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(queue_empty_error && switched))
        else $error("empty-queue error together with a dispatch");

    a_keep_no_switch: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(tick_clear && switched))
        else $error("kept thread reported as switched");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (q_op == pts_pkg::Q_POP) |-> (q_count != '0))
        else $error("pop from empty ready queue");
`endif

endmodule
